@@ rtl/core/itd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the integer to decimal text converter.
// No dependencies; every other file imports this package.
package itd_pkg;

    // Default width of the converted integer
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths on the channels
    localparam int IN_W   = 32;
    localparam int CHAR_W = 6;

    // ASCII codes, cut to the character field width
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_PREP,
        ST_SIGN,
        ST_DIGIT
    } itd_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic prep;
        logic emit_sign;
        logic emit_digit;
    } itd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_step;
        logic negative;
        logic idx_zero;
        logic out_free;
    } itd_sts_t;

endpackage

@@ rtl/core/itd_ifs.sv @@
`timescale 1ns / 1ps
// Handshake channel interfaces: one for the input integer, one for text characters.
// Depends on itd_pkg for field widths.
interface itd_value_if import itd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itd_char_if import itd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/core/itd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences load, BCD conversion, and character emission.
// Depends on itd_pkg for the state, command and status types.
module itd_ctrl import itd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  itd_sts_t sts,
    output itd_cmd_t cmd
);

    itd_state_t state_reg;
    itd_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (sts.last_step)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = sts.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (sts.out_free && sts.idx_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = sts.out_free;
            end
            ST_DIGIT:
            begin
                cmd.emit_digit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/itd_dp.sv @@
`timescale 1ns / 1ps
// Datapath: magnitude register, shift-and-add-3 BCD converter (four bits per cycle),
// digit index and output register. Depends on itd_pkg.
module itd_dp import itd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  itd_cmd_t               cmd,
    input  logic signed [IN_W-1:0] value,
    output itd_sts_t               sts,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [CHAR_W-1:0]      out_char,
    output logic                   out_last
);

    // Magnitude padded to whole nibbles; decimal digit count that covers 2^(VALUE_BITS-1)
    localparam int MAG_W  = ((VALUE_BITS + 3) / 4) * 4;
    localparam int STEPS  = MAG_W / 4;
    localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int IDX_W  = $clog2(NDIG);
    localparam int STEP_W = $clog2(STEPS);

    logic [VALUE_BITS-1:0] raw;
    logic                  negative;
    logic [VALUE_BITS-1:0] mag;
    logic [MAG_W-1:0]      mag_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [STEP_W-1:0]     step_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      msd;
    logic                  neg_reg;
    logic                  valid_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;
    logic [3:0]            nib;
    logic [3:0]            digit;

    // Take the low VALUE_BITS bits; wider settings see zeros above the input field
    if (VALUE_BITS <= IN_W)
    begin : g_narrow
        assign raw = value[VALUE_BITS-1:0];
    end
    else
    begin : g_wide
        assign raw = {{(VALUE_BITS - IN_W){1'b0}}, value};
    end

    assign negative = raw[VALUE_BITS-1];
    assign mag      = negative ? (~raw + VALUE_BITS'(1)) : raw;
    assign nib      = mag_reg[MAG_W-1 -: 4];

    // Four double-dabble steps: correct each digit, then shift in the next bit
    always_comb
    begin
        bcd_next = bcd_reg;
        for (int b = 0; b < 4; b++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (bcd_next[d*4 +: 4] >= 4'd5)
                begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], nib[3-b]};
        end
    end

    // Find the most significant nonzero digit
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                msd = IDX_W'(d);
            end
        end
    end

    assign digit = bcd_reg[idx_reg*4 +: 4];

    // Conversion registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg  <= MAG_W'(mag);
            neg_reg  <= negative;
            bcd_reg  <= '0;
            step_reg <= STEP_W'(STEPS - 1);
        end
        else if (cmd.shift)
        begin
            mag_reg  <= mag_reg << 4;
            bcd_reg  <= bcd_next;
            step_reg <= step_reg - STEP_W'(1);
        end
        if (cmd.prep)
        begin
            idx_reg <= msd;
        end
        else if (cmd.emit_digit)
        begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
    end

    // Output valid: set on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= CHAR_ZERO + CHAR_W'(digit);
            last_reg <= (idx_reg == '0);
        end
    end

    assign sts.last_step = (step_reg == '0);
    assign sts.negative  = neg_reg;
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.out_free  = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

@@ rtl/core/integer_to_decimal_text_top.sv @@
`timescale 1ns / 1ps
// Signed integer to decimal ASCII text, one character per output item, MSB digit first.
// A taken number is loaded and run through the four-bit-per-cycle BCD converter; a prep state
// then picks the leading digit, and the optional minus sign and the digits go out one character
// per cycle while text.ready does not stall. A new number is taken only once the last is emitted.
// Reset: rst_n asynchronous, active low; clears the controller and output valid.
module integer_to_decimal_text_top import itd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    itd_value_if.sink         num,
    itd_char_if.source        text
);

    itd_cmd_t cmd;
    itd_sts_t sts;

    itd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (num.valid),
        .in_ready (num.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itd_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (num.value),
        .sts       (sts),
        .out_ready (text.ready),
        .out_valid (text.valid),
        .out_char  (text.character),
        .out_last  (text.last)
    );

`ifndef SYNTHESIS
    // A taken number starts conversion on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (num.valid && num.ready) |=> cmd.shift)
        else $error("conversion did not start after a number was taken");

    // Never emit while ready for a new number
    assert property (@(posedge clk) disable iff (!rst_n)
        num.ready |-> !(cmd.emit_sign || cmd.emit_digit))
        else $error("character emitted while idle");

    // One minus sign per number, followed by digits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sign |=> !cmd.emit_sign && !num.ready)
        else $error("minus sign repeated or number dropped after sign");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for integer_to_decimal_text_top: drives signed integers, predicts
// the decimal text of each and checks every character item in order.
// Depends on itd_pkg, the itd_value_if / itd_char_if interfaces and the RTL top.
module tb_top;
    import itd_pkg::*;

    localparam int VB        = VALUE_BITS_DEF;
    localparam int RADIX     = 10;
    localparam int MAX_WAIT  = 10;
    localparam int DRAIN_CYC = 12;

    typedef struct {
        logic [IN_W-1:0] value;
        int              gap;
    } num_item_t;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last;
    } char_item_t;

    logic clk;
    logic rst_n = 1'b0;

    itd_value_if num_if ();
    itd_char_if  text_if ();

    integer_to_decimal_text_top #(
        .VALUE_BITS (VB)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_if),
        .text  (text_if)
    );

    num_item_t  pending_nums[$];
    char_item_t expected_chars[$];
    int         mismatch_count = 0;
    int         gap_cnt;
    int         stall_cnt;
    int         cycle_cnt;

    // Push the decimal text of one integer, most significant character first
    function automatic void push_decimal_text(input logic [IN_W-1:0] value);
        logic [63:0]       mask;
        logic [63:0]       raw;
        logic [63:0]       mag;
        logic              negative;
        logic [3:0]        digit;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] rev[$];
        char_item_t        item;
        mask     = (VB >= 64) ? {64{1'b1}} : ((64'd1 << VB) - 64'd1);
        raw      = {32'd0, value} & mask;
        negative = raw[VB-1];
        mag      = negative ? ((~raw + 64'd1) & mask) : raw;
        do
        begin
            digit = 4'(mag % RADIX);
            ch    = CHAR_ZERO + digit;
            rev.push_back(ch);
            mag   = mag / RADIX;
        end
        while (mag != 0);
        if (negative)
            rev.push_back(CHAR_MINUS);
        for (int k = rev.size() - 1; k >= 0; k--)
        begin
            item.character = rev[k];
            item.last      = (k == 0);
            expected_chars.push_back(item);
        end
    endfunction

    // Queue one number with its lead-in gap
    task automatic queue_num(input logic [IN_W-1:0] value, input int gap);
        num_item_t item;
        item.value = value;
        item.gap   = gap;
        pending_nums.push_back(item);
    endtask

    // Draw a signed value, mostly spread over all digit counts
    function automatic logic [IN_W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     d;
        int     mode;
        mode = $urandom_range(0, 9);
        if (mode >= 6 && mode <= 7)
            return $urandom;
        d  = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < d; i++)
            lo = lo * RADIX;
        hi = lo * RADIX - 1;
        if (d == 1)
            lo = 0;
        if (hi > 64'sd2147483647)
            hi = 64'sd2147483647;
        if (mode >= 8)
            mag = $urandom_range(0, 1) ? hi : ((d == 1) ? 1 : lo);
        else
            mag = lo + (longint'($urandom) % (hi - lo + 1));
        if ($urandom_range(0, 1))
            mag = -mag;
        if (mode >= 8 && d == 10 && mag < 0 && $urandom_range(0, 1))
            mag = mag - 1;
        return mag[IN_W-1:0];
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles to pace the no-stall stretches on the text side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_cnt <= 0;
        else
            cycle_cnt <= cycle_cnt + 1;
    end

    // Number driver: hold each item until taken, predict its text on accept
    always @(posedge clk or negedge rst_n)
    begin
        logic            v_valid;
        logic [IN_W-1:0] v_value;
        int              v_gap;
        num_item_t       head;
        if (!rst_n)
        begin
            num_if.valid <= 1'b0;
            num_if.value <= '0;
            gap_cnt      <= 0;
        end
        else
        begin
            v_valid = num_if.valid;
            v_value = num_if.value;
            v_gap   = gap_cnt;
            if (num_if.valid && num_if.ready)
            begin
                push_decimal_text(num_if.value);
                v_valid = 1'b0;
                v_gap   = 0;
            end
            if (!v_valid && pending_nums.size() != 0)
            begin
                head = pending_nums[0];
                if (v_gap < head.gap)
                    v_gap = v_gap + 1;
                else
                begin
                    head    = pending_nums.pop_front();
                    v_value = head.value;
                    v_valid = 1'b1;
                    v_gap   = 0;
                end
            end
            num_if.valid <= v_valid;
            num_if.value <= v_value;
            gap_cnt      <= v_gap;
        end
    end

    // Text monitor: stall ready at random, compare each item with the oldest expected
    always @(posedge clk or negedge rst_n)
    begin
        int         v_stall;
        char_item_t want;
        if (!rst_n)
        begin
            text_if.ready <= 1'b0;
            stall_cnt     <= 0;
        end
        else
        begin
            v_stall = stall_cnt;
            if (text_if.valid && text_if.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected item, got character %0d last %0b",
                             $time, text_if.character, text_if.last);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (text_if.character !== want.character)
                    begin
                        mismatch_count++;
                        $display("%0t: character mismatch, expected %0d got %0d",
                                 $time, want.character, text_if.character);
                    end
                    if (text_if.last !== want.last)
                    begin
                        mismatch_count++;
                        $display("%0t: last mismatch, expected %0b got %0b",
                                 $time, want.last, text_if.last);
                    end
                end
                v_stall = ((cycle_cnt % 1024) < 256) ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (v_stall > 0)
            begin
                text_if.ready <= 1'b0;
                stall_cnt     <= v_stall - 1;
            end
            else
            begin
                text_if.ready <= 1'b1;
                stall_cnt     <= 0;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [IN_W-1:0] directed[$];
        int              gap;
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                     32'sd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'sd1000000000, 32'sd999999999, -32'sd999999999,
                     -32'sd1000000000, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'sd123456789, -32'sd123456789, 32'sd7, -32'sd7};
        foreach (directed[i])
            queue_num(directed[i], $urandom_range(0, MAX_WAIT));
        // random part: a back-to-back stretch in the middle
        for (int i = 0; i < 140; i++)
        begin
            gap = (i >= 60 && i < 100) ? 0 : $urandom_range(0, MAX_WAIT);
            queue_num(random_value(), gap);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_nums.size() != 0 || num_if.valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS integer_to_decimal_text_top");
        else
            $display("FAIL integer_to_decimal_text_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("FAIL integer_to_decimal_text_top");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/itd_pkg.sv
rtl/core/itd_ifs.sv
rtl/core/itd_ctrl.sv
rtl/core/itd_dp.sv
rtl/core/integer_to_decimal_text_top.sv
tb/tb_top.sv
